// ----- design/ffba_pkg.sv -----
// Shared types and constants of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int ADDR_W      = 16;
    localparam int BYTES_W     = 17;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADPTR  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DIVB,
        S_DIVA,
        S_FR_RD,
        S_FR_CHK,
        S_RA_EVAL,
        S_RA_RDN,
        S_RA_DN,
        S_AL_RD,
        S_AL_CHK,
        S_SP_CHK,
        S_SP_LNK,
        S_SP_AFT,
        S_MN_RD,
        S_MN_D,
        S_MN_RDN,
        S_MN_DN,
        S_AB_SZ,
        S_AB_CLR,
        S_AB_LNK,
        S_FP_RD,
        S_FP_D,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        CTX_ALLOC,
        CTX_FREE,
        CTX_REAL,
        CTX_RFREE,
        CTX_INPLACE,
        CTX_MOVE
    } ctx_t;

    typedef enum logic [1:0] {
        RET_FREE1,
        RET_FREE2,
        RET_GROW
    } ret_t;

    typedef struct packed {
        logic size;
        logic prev;
        logic start;
        logic used;
        logic pv;
    } mem_we_t;

endpackage

// ----- design/ffba_div.sv -----
// Divider by a fixed divisor using a reciprocal multiplication, result registered for the cycle after start.
`timescale 1ns / 1ps

module ffba_div
    import ffba_pkg::*;
#(
    parameter int DIVISOR = 8,
    localparam int RW = $clog2(DIVISOR)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BYTES_W-1:0] dividend,
    output logic [BYTES_W-1:0] quotient,
    output logic [RW-1:0]      remainder,
    output logic               done
);

    localparam int SH = BYTES_W + RW;
    localparam int MW = BYTES_W + 2;
    localparam int PW = BYTES_W + MW;
    localparam longint MUL = ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [MW-1:0] MUL_V = MW'(MUL);

    logic               done_reg, done_next;
    logic [BYTES_W-1:0] quo_reg, quo_next;
    logic [BYTES_W-1:0] dvd_reg, dvd_next;
    logic [PW-1:0]      prod;
    logic [BYTES_W-1:0] back;
    logic [BYTES_W-1:0] diff;

    assign prod = PW'(dividend) * PW'(MUL_V);

    always_comb
    begin
        done_next = start;
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            quo_next = BYTES_W'(prod >> SH);
            dvd_next = dividend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
    end

    assign back      = quo_reg * BYTES_W'(DIVISOR);
    assign diff      = dvd_reg - back;
    assign quotient  = quo_reg;
    assign remainder = diff[RW-1:0];
    assign done      = done_reg;

endmodule

// ----- design/ffba_mem.sv -----
// Block metadata memories indexed by pool unit, one write and one registered read per cycle.
`timescale 1ns / 1ps

module ffba_mem
    import ffba_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int UW    = 13,
    parameter int SW    = 14
)
(
    input  logic          clk,
    input  logic [UW-1:0] rd_addr,
    output logic [SW-1:0] q_size,
    output logic [UW-1:0] q_prev,
    output logic          q_start,
    output logic          q_used,
    output logic          q_pv,
    input  mem_we_t       we,
    input  logic [UW-1:0] wr_addr,
    input  logic [SW-1:0] wr_size,
    input  logic [UW-1:0] wr_prev,
    input  logic          wr_start,
    input  logic          wr_used,
    input  logic          wr_pv
);

    logic [SW-1:0] size_mem  [DEPTH];
    logic [UW-1:0] prev_mem  [DEPTH];
    logic          start_mem [DEPTH];
    logic          used_mem  [DEPTH];
    logic          pv_mem    [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.size)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        if (we.prev)
        begin
            prev_mem[wr_addr] <= wr_prev;
        end
        if (we.start)
        begin
            start_mem[wr_addr] <= wr_start;
        end
        if (we.used)
        begin
            used_mem[wr_addr] <= wr_used;
        end
        if (we.pv)
        begin
            pv_mem[wr_addr] <= wr_pv;
        end
        q_size  <= size_mem[rd_addr];
        q_prev  <= prev_mem[rd_addr];
        q_start <= start_mem[rd_addr];
        q_used  <= used_mem[rd_addr];
        q_pv    <= pv_mem[rd_addr];
    end

endmodule

// ----- design/ffba_seq.sv -----
// Sequencer that walks, splits and merges blocks and holds the result register.
`timescale 1ns / 1ps

module ffba_seq
    import ffba_pkg::*;
#(
    parameter int NUNITS      = 8192,
    parameter int HDR_UNITS   = 4,
    parameter int ALIGN_BYTES = 8,
    parameter int UW          = 13,
    parameter int SW          = 14,
    parameter int CW          = 19,
    parameter int RW          = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    in_op,
    input  logic [ADDR_W-1:0]  in_addr,
    input  logic [BYTES_W-1:0] in_bytes,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  out_addr,
    output status_t            out_status,
    output logic [BYTES_W-1:0] out_copy,
    output logic               div_start,
    output logic [BYTES_W-1:0] div_dividend,
    input  logic [BYTES_W-1:0] div_q,
    input  logic [RW-1:0]      div_r,
    input  logic               div_done,
    output logic [UW-1:0]      rd_addr,
    input  logic [SW-1:0]      q_size,
    input  logic [UW-1:0]      q_prev,
    input  logic               q_start,
    input  logic               q_used,
    input  logic               q_pv,
    output mem_we_t            we,
    output logic [UW-1:0]      wr_addr,
    output logic [SW-1:0]      wr_size,
    output logic [UW-1:0]      wr_prev,
    output logic               wr_start,
    output logic               wr_used,
    output logic               wr_pv
);

    localparam logic [31:0] OFF   = 32'(HDR_UNITS * ALIGN_BYTES);
    localparam logic [31:0] LIMIT = 32'(NUNITS * ALIGN_BYTES);
    localparam logic [CW-1:0] N_C = CW'(NUNITS);

    seq_state_t         state_reg, state_next;
    ctx_t               ctx_reg, ctx_next;
    ret_t               ret_reg, ret_next;
    op_t                op_reg, op_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [CW-1:0]      need_reg, need_next;
    logic [UW-1:0]      cur_reg, cur_next;
    logic [UW-1:0]      blk_reg, blk_next;
    logic [UW-1:0]      nb_reg, nb_next;
    logic [UW-1:0]      p_reg, p_next;
    logic [UW-1:0]      clr_reg, clr_next;
    logic [SW-1:0]      sz_reg, sz_next;
    logic               pv_reg, pv_next;
    logic [ADDR_W-1:0]  res_reg, res_next;
    status_t            status_reg, status_next;
    logic [BYTES_W-1:0] copy_reg, copy_next;
    logic               ov_reg;
    logic [ADDR_W-1:0]  oa_reg;
    status_t            os_reg;
    logic [BYTES_W-1:0] oc_reg;

    logic               ptr_ok, bad_blk, out_free, load;
    logic [CW-1:0]      q_sz_ext, walk_next, rem, sp_nb, after, grow_sum, nb_ra, need_calc;
    logic               fit, split_ok, after_ok;
    logic [31:0]        payload_cur, cur_payload;
    logic [BYTES_W-1:0] addr_off, copy_calc;
    seq_state_t         mret_state;

    assign ptr_ok      = (32'(addr_reg) >= OFF) && (32'(addr_reg) < LIMIT);
    assign addr_off    = BYTES_W'(32'(addr_reg) - OFF);
    assign q_sz_ext    = CW'(q_size);
    assign walk_next   = CW'(cur_reg) + q_sz_ext;
    assign fit         = !q_used && (q_sz_ext >= need_reg);
    assign rem         = CW'(sz_reg) - need_reg;
    assign split_ok    = rem >= CW'(HDR_UNITS + 1);
    assign sp_nb       = CW'(cur_reg) + need_reg;
    assign after       = CW'(cur_reg) + CW'(sz_reg);
    assign after_ok    = after < N_C;
    assign grow_sum    = CW'(sz_reg) + q_sz_ext;
    assign nb_ra       = CW'(blk_reg) + CW'(sz_reg);
    assign need_calc   = CW'(HDR_UNITS) + CW'(div_q) + CW'(div_r != '0);
    assign payload_cur = (32'(cur_reg) + 32'(HDR_UNITS)) * 32'(ALIGN_BYTES);
    assign cur_payload = (32'(sz_reg) - 32'(HDR_UNITS)) * 32'(ALIGN_BYTES);
    assign copy_calc   = (cur_payload < 32'(bytes_reg)) ? cur_payload[BYTES_W-1:0] : bytes_reg;
    assign bad_blk     = (ctx_reg != CTX_MOVE) && (!q_start || !q_used);
    assign out_free    = !ov_reg || out_ready;
    assign load        = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        unique case (ret_reg)
            RET_FREE1: mret_state = pv_reg ? S_FP_RD : S_DONE;
            RET_GROW:  mret_state = S_SP_CHK;
            default:   mret_state = S_DONE;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ctx_next    = ctx_reg;
        ret_next    = ret_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        bytes_next  = bytes_reg;
        need_next   = need_reg;
        cur_next    = cur_reg;
        blk_next    = blk_reg;
        nb_next     = nb_reg;
        p_next      = p_reg;
        clr_next    = clr_reg;
        sz_next     = sz_reg;
        pv_next     = pv_reg;
        res_next    = res_reg;
        status_next = status_reg;
        copy_next   = copy_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == UW'(NUNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(in_op);
                    addr_next   = in_addr;
                    bytes_next  = in_bytes;
                    res_next    = '0;
                    copy_next   = '0;
                    status_next = ST_NOSPACE;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        ctx_next   = CTX_ALLOC;
                        state_next = (bytes_reg == '0) ? S_DONE : S_DIVB;
                    end
                    OP_FREE:
                    begin
                        ctx_next = CTX_FREE;
                        if (addr_reg == '0)
                        begin
                            status_next = ST_DONE;
                            state_next  = S_DONE;
                        end
                        else if (!ptr_ok)
                        begin
                            status_next = ST_BADPTR;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DIVA;
                        end
                    end
                    OP_REALLOC:
                    begin
                        if (addr_reg == '0)
                        begin
                            ctx_next   = CTX_ALLOC;
                            state_next = (bytes_reg == '0) ? S_DONE : S_DIVB;
                        end
                        else if (!ptr_ok)
                        begin
                            status_next = ST_BADPTR;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ctx_next   = CTX_REAL;
                            state_next = S_DIVA;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIVB:
            begin
                if (div_done)
                begin
                    need_next = need_calc;
                    if (ctx_reg != CTX_ALLOC)
                    begin
                        state_next = S_RA_EVAL;
                    end
                    else if (need_calc > N_C)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next   = '0;
                        state_next = S_AL_RD;
                    end
                end
            end
            S_DIVA:
            begin
                if (div_done)
                begin
                    if (div_r != '0)
                    begin
                        status_next = ST_BADPTR;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        blk_next   = UW'(32'(div_q));
                        state_next = S_FR_RD;
                    end
                end
            end
            S_FR_RD:
            begin
                state_next = S_FR_CHK;
            end
            S_FR_CHK:
            begin
                if (bad_blk)
                begin
                    status_next = ST_BADPTR;
                    state_next  = S_DONE;
                end
                else if (ctx_reg == CTX_REAL && bytes_reg != '0)
                begin
                    sz_next    = q_size;
                    state_next = S_DIVB;
                end
                else
                begin
                    if (ctx_reg == CTX_REAL)
                    begin
                        ctx_next = CTX_RFREE;
                    end
                    pv_next    = q_pv;
                    p_next     = q_prev;
                    cur_next   = blk_reg;
                    ret_next   = RET_FREE1;
                    state_next = S_MN_RD;
                end
            end
            S_RA_EVAL:
            begin
                if (need_reg <= CW'(sz_reg))
                begin
                    cur_next   = blk_reg;
                    ctx_next   = CTX_INPLACE;
                    state_next = S_SP_CHK;
                end
                else if (nb_ra < N_C)
                begin
                    nb_next    = nb_ra[UW-1:0];
                    state_next = S_RA_RDN;
                end
                else if (need_reg > N_C)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctx_next   = CTX_MOVE;
                    copy_next  = copy_calc;
                    cur_next   = '0;
                    state_next = S_AL_RD;
                end
            end
            S_RA_RDN:
            begin
                state_next = S_RA_DN;
            end
            S_RA_DN:
            begin
                if (q_start && !q_used && grow_sum >= need_reg)
                begin
                    cur_next   = blk_reg;
                    sz_next    = grow_sum[SW-1:0];
                    ctx_next   = CTX_INPLACE;
                    ret_next   = RET_GROW;
                    state_next = S_AB_SZ;
                end
                else if (need_reg > N_C)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctx_next   = CTX_MOVE;
                    copy_next  = copy_calc;
                    cur_next   = '0;
                    state_next = S_AL_RD;
                end
            end
            S_AL_RD:
            begin
                state_next = S_AL_CHK;
            end
            S_AL_CHK:
            begin
                if (fit)
                begin
                    sz_next    = q_size;
                    state_next = S_SP_CHK;
                end
                else if (q_size == '0 || walk_next >= N_C)
                begin
                    copy_next   = '0;
                    status_next = ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = walk_next[UW-1:0];
                    state_next = S_AL_RD;
                end
            end
            S_SP_CHK, S_SP_LNK, S_SP_AFT:
            begin
                if (state_reg == S_SP_CHK && split_ok)
                begin
                    nb_next    = sp_nb[UW-1:0];
                    state_next = S_SP_LNK;
                end
                else if (state_reg == S_SP_LNK && after_ok)
                begin
                    state_next = S_SP_AFT;
                end
                else
                begin
                    case (ctx_reg)
                        CTX_MOVE:
                        begin
                            res_next   = payload_cur[ADDR_W-1:0];
                            state_next = S_FR_RD;
                        end
                        CTX_INPLACE:
                        begin
                            res_next    = addr_reg;
                            status_next = ST_DONE;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            res_next    = payload_cur[ADDR_W-1:0];
                            status_next = ST_DONE;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_MN_RD:
            begin
                state_next = S_MN_D;
            end
            S_MN_D:
            begin
                if (q_used || walk_next >= N_C)
                begin
                    state_next = mret_state;
                end
                else
                begin
                    sz_next    = q_size;
                    nb_next    = walk_next[UW-1:0];
                    state_next = S_MN_RDN;
                end
            end
            S_MN_RDN:
            begin
                state_next = S_MN_DN;
            end
            S_MN_DN:
            begin
                if (q_start && !q_used)
                begin
                    sz_next    = grow_sum[SW-1:0];
                    state_next = S_AB_SZ;
                end
                else
                begin
                    state_next = mret_state;
                end
            end
            S_AB_SZ:
            begin
                state_next = S_AB_CLR;
            end
            S_AB_CLR:
            begin
                state_next = after_ok ? S_AB_LNK : mret_state;
            end
            S_AB_LNK:
            begin
                state_next = mret_state;
            end
            S_FP_RD:
            begin
                state_next = S_FP_D;
            end
            S_FP_D:
            begin
                if (q_start && !q_used)
                begin
                    cur_next   = p_reg;
                    ret_next   = RET_FREE2;
                    state_next = S_MN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_next == S_DONE && state_reg != S_DONE && ret_reg != RET_GROW &&
            (state_reg == S_MN_D || state_reg == S_MN_DN || state_reg == S_AB_CLR ||
             state_reg == S_AB_LNK || state_reg == S_FP_D))
        begin
            status_next = ST_DONE;
        end
    end

    always_comb
    begin
        in_ready     = (state_reg == S_IDLE);
        div_start    = 1'b0;
        div_dividend = bytes_reg;
        rd_addr      = cur_reg;
        we           = '0;
        wr_addr      = cur_reg;
        wr_size      = '0;
        wr_prev      = '0;
        wr_start     = 1'b0;
        wr_used      = 1'b0;
        wr_pv        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we       = '1;
                wr_addr  = clr_reg;
                wr_size  = (clr_reg == '0) ? SW'(NUNITS) : '0;
                wr_start = (clr_reg == '0);
            end
            S_DECODE:
            begin
                if (op_reg == OP_ALLOC || (op_reg == OP_REALLOC && addr_reg == '0))
                begin
                    div_start = (bytes_reg != '0);
                end
                else if (op_reg == OP_FREE || op_reg == OP_REALLOC)
                begin
                    div_start    = (addr_reg != '0) && ptr_ok;
                    div_dividend = addr_off;
                end
            end
            S_FR_RD:
            begin
                rd_addr = blk_reg;
            end
            S_FR_CHK:
            begin
                if (!bad_blk)
                begin
                    if (ctx_reg == CTX_REAL && bytes_reg != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        we.used = 1'b1;
                        wr_addr = blk_reg;
                    end
                end
            end
            S_RA_RDN, S_MN_RDN:
            begin
                rd_addr = nb_reg;
            end
            S_SP_CHK:
            begin
                if (split_ok)
                begin
                    we       = '1;
                    wr_addr  = sp_nb[UW-1:0];
                    wr_size  = rem[SW-1:0];
                    wr_prev  = cur_reg;
                    wr_start = 1'b1;
                    wr_pv    = 1'b1;
                end
                else
                begin
                    we.used = 1'b1;
                    wr_used = 1'b1;
                end
            end
            S_SP_LNK:
            begin
                we.size = 1'b1;
                we.used = 1'b1;
                wr_size = need_reg[SW-1:0];
                wr_used = 1'b1;
            end
            S_SP_AFT:
            begin
                we.prev = 1'b1;
                we.pv   = 1'b1;
                wr_addr = after[UW-1:0];
                wr_prev = nb_reg;
                wr_pv   = 1'b1;
            end
            S_AB_SZ:
            begin
                we.size = 1'b1;
                wr_size = sz_reg;
            end
            S_AB_CLR:
            begin
                we.start = 1'b1;
                we.pv    = 1'b1;
                wr_addr  = nb_reg;
            end
            S_AB_LNK:
            begin
                we.prev = 1'b1;
                we.pv   = 1'b1;
                wr_addr = after[UW-1:0];
                wr_prev = cur_reg;
                wr_pv   = 1'b1;
            end
            S_FP_RD:
            begin
                rd_addr = p_reg;
            end
            default:
            begin
                rd_addr = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg    <= ctx_next;
        ret_reg    <= ret_next;
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        bytes_reg  <= bytes_next;
        need_reg   <= need_next;
        cur_reg    <= cur_next;
        blk_reg    <= blk_next;
        nb_reg     <= nb_next;
        p_reg      <= p_next;
        sz_reg     <= sz_next;
        pv_reg     <= pv_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        copy_reg   <= copy_next;
        if (load)
        begin
            oa_reg <= res_reg;
            os_reg <= status_reg;
            oc_reg <= copy_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign out_addr   = oa_reg;
    assign out_status = os_reg;
    assign out_copy   = oc_reg;

endmodule

// ----- design/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit block allocator.
`timescale 1ns / 1ps

// First-fit allocator for a pool of POOL_BYTES bytes kept in units of ALIGN_BYTES. It takes one
// request at a time (allocate, free or reallocate) and answers each with one result. After reset
// a clearing pass runs through all POOL_BYTES / ALIGN_BYTES entries of the metadata memory before
// the first request is taken. A request is accepted and decoded, the divider turns a byte count or
// an address into units (a reallocate of a live block to a nonzero size makes two divider passes),
// the header of a block that is freed or reallocated is read and checked, and the result is handed
// over. The first-fit walk reads and checks each block visited in turn. A split, when the remainder
// is large enough, writes the new free block, the shortened block and the back link of the block
// after it. A freed block is merged with a free block after it and then with a free block before
// it. A reallocate chooses between shrinking, growing and moving, and grows by absorbing the next
// block. A moving reallocate pays for a walk, a split and a free. The result waits in an output
// register, so the next request may be taken while it is unread.

module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // address [15:0], size_bytes [32:16], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_address [15:0], copy_bytes [32:16], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    localparam int NUNITS    = POOL_BYTES / ALIGN_BYTES;
    localparam int HDR_UNITS = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int UW        = $clog2(NUNITS);
    localparam int SW        = UW + 1;
    localparam int CW        = ((SW > BYTES_W) ? SW : BYTES_W) + 2;
    localparam int RW        = $clog2(ALIGN_BYTES);

    logic               div_start, div_done;
    logic [BYTES_W-1:0] div_dividend, div_q;
    logic [RW-1:0]      div_r;
    logic [UW-1:0]      rd_addr, wr_addr, q_prev, wr_prev;
    logic [SW-1:0]      q_size, wr_size;
    logic               q_start, q_used, q_pv, wr_start, wr_used, wr_pv;
    mem_we_t            we;
    logic [ADDR_W-1:0]  out_addr;
    status_t            out_status;
    logic [BYTES_W-1:0] out_copy;

    ffba_div #(.DIVISOR(ALIGN_BYTES)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    ffba_mem #(.DEPTH(NUNITS), .UW(UW), .SW(SW)) u_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .q_size   (q_size),
        .q_prev   (q_prev),
        .q_start  (q_start),
        .q_used   (q_used),
        .q_pv     (q_pv),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_size  (wr_size),
        .wr_prev  (wr_prev),
        .wr_start (wr_start),
        .wr_used  (wr_used),
        .wr_pv    (wr_pv)
    );

    ffba_seq #(
        .NUNITS      (NUNITS),
        .HDR_UNITS   (HDR_UNITS),
        .ALIGN_BYTES (ALIGN_BYTES),
        .UW          (UW),
        .SW          (SW),
        .CW          (CW),
        .RW          (RW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_addr      (s_axis_tdata[ADDR_W-1:0]),
        .in_bytes     (s_axis_tdata[ADDR_W+BYTES_W-1:ADDR_W]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_addr     (out_addr),
        .out_status   (out_status),
        .out_copy     (out_copy),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_q        (div_q),
        .div_r        (div_r),
        .div_done     (div_done),
        .rd_addr      (rd_addr),
        .q_size       (q_size),
        .q_prev       (q_prev),
        .q_start      (q_start),
        .q_used       (q_used),
        .q_pv         (q_pv),
        .we           (we),
        .wr_addr      (wr_addr),
        .wr_size      (wr_size),
        .wr_prev      (wr_prev),
        .wr_start     (wr_start),
        .wr_used      (wr_used),
        .wr_pv        (wr_pv)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - ADDR_W - BYTES_W)'(0), out_copy, out_addr};
    assign m_axis_tuser = out_status;

endmodule

// ----- design/ffba_check.sv -----
// Port-level checker for the first-fit block allocator and its bind.
`timescale 1ns / 1ps

module ffba_check
    import ffba_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [OP_W-1:0]        s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]    m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result changed while stalled.");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("A second request was taken while one was in progress.");

    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DONE |->
            m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[32:16] == 17'd0)
        else $error("A failed request returned an address or a copy length.");

    a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32:16] != 17'd0 |-> m_axis_tuser == ST_DONE)
        else $error("A copy length came with a failure status.");

endmodule

bind first_fit_block_allocator_unit ffba_check u_ffba_check (.*);
